// ===== rtl/sfr_pkg.sv =====
package sfr_pkg;

    // Window capacity in bytes; the pattern is compared over at most this many
    localparam int WIN_BYTES = 8;
    localparam int WIN_BITS  = 8 * WIN_BYTES;

    // Configuration register indexes
    typedef enum logic [1:0] {
        CFG_PATTERN_BYTES      = 2'd0,
        CFG_PATTERN_LENGTH     = 2'd1,
        CFG_REPLACEMENT_BYTES  = 2'd2,
        CFG_REPLACEMENT_LENGTH = 2'd3
    } t_cfg_idx;

    // Input word
    typedef struct packed {
        logic [7:0] in_byte;
        logic       in_last;
    } t_in_word;

    // Output word
    typedef struct packed {
        logic [7:0] out_byte;
        logic       byte_valid;
        logic       out_last;
    } t_out_word;

    // Burst of results caused by one input word
    typedef struct packed {
        logic [WIN_BITS-1:0] bytes;   // first word in bits 7:0
        logic [2:0]          left;    // words in burst minus one
        logic                marker;  // end marker only, no character
        logic                last;    // final word of burst closes the text
    } t_burst;

    // Mask covering the lowest n bytes of a window
    function automatic logic [WIN_BITS-1:0] byte_mask(input logic [3:0] n);
        logic [WIN_BITS-1:0] m;
        m = '0;
        for (int i = 0; i < WIN_BYTES; i++) begin
            m[8*i +: 8] = (4'(i) < n) ? 8'hFF : 8'h00;
        end
        return m;
    endfunction

endpackage

// ===== rtl/sfr_window.sv =====
module sfr_window #(
    parameter int MAX_PATTERN = 8
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  sfr_pkg::t_cfg_idx     i_cfg_idx,
    input  logic [63:0]           i_cfg_data,
    input  logic                  i_take,
    input  sfr_pkg::t_in_word     i_word,
    output logic                  o_load,
    output sfr_pkg::t_burst       o_burst
);
    import sfr_pkg::*;

    localparam int CAP_INT = (MAX_PATTERN > WIN_BYTES) ? WIN_BYTES :
                             ((MAX_PATTERN < 1) ? 1 : MAX_PATTERN);
    localparam logic [3:0] CAP = 4'(CAP_INT);

    logic [WIN_BITS-1:0] r_pat, r_repl, r_win, n_win;
    logic [3:0]          r_plen, r_rlen, r_cnt, n_cnt;

    logic [WIN_BITS-1:0] kept, ins, plen_mask;
    logic [3:0]          cnt_kept, cnt_ins, n_emit, drop;
    logic                full, hit;

    // Window update and burst build for the incoming word
    always_comb begin
        // drop oldest bytes if the count is not below the pattern length
        drop     = r_cnt - r_plen + 4'd1;
        kept     = r_win;
        cnt_kept = r_cnt;
        if (r_cnt >= r_plen) begin
            kept     = r_win >> {drop, 3'b000};
            cnt_kept = r_plen - 4'd1;
        end

        ins       = (kept & byte_mask(cnt_kept)) |
                    ({{(WIN_BITS-8){1'b0}}, i_word.in_byte} << {cnt_kept, 3'b000});
        cnt_ins   = cnt_kept + 4'd1;
        full      = (cnt_ins == r_plen);
        plen_mask = byte_mask(r_plen);
        hit       = full && ((ins & plen_mask) == (r_pat & plen_mask));

        o_burst.bytes = ins;
        if (hit) begin
            o_burst.bytes = r_repl;
            n_emit        = r_rlen;
            n_win         = '0;
            n_cnt         = 4'd0;
        end else if (full) begin
            // oldest byte goes out; on the last word the whole window does
            n_emit = i_word.in_last ? r_plen : 4'd1;
            n_win  = ins >> 8;
            n_cnt  = cnt_ins - 4'd1;
        end else begin
            n_emit = i_word.in_last ? cnt_ins : 4'd0;
            n_win  = ins;
            n_cnt  = cnt_ins;
        end

        // end of text leaves the window empty
        if (i_word.in_last) begin
            n_win = '0;
            n_cnt = 4'd0;
        end

        o_burst.marker = (n_emit == 4'd0);
        o_burst.left   = (n_emit == 4'd0) ? 3'd0 : 3'(n_emit - 4'd1);
        o_burst.last   = i_word.in_last;
        o_load         = i_take && ((n_emit != 4'd0) || i_word.in_last);
    end

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pat  <= '0;
            r_plen <= 4'd1;
            r_repl <= '0;
            r_rlen <= 4'd0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_PATTERN_BYTES: begin
                    r_pat <= i_cfg_data[WIN_BITS-1:0];
                end
                CFG_PATTERN_LENGTH: begin
                    if (i_cfg_data[3:0] == 4'd0) begin
                        r_plen <= 4'd1;
                    end else if (i_cfg_data[3:0] > CAP) begin
                        r_plen <= CAP;
                    end else begin
                        r_plen <= i_cfg_data[3:0];
                    end
                end
                CFG_REPLACEMENT_BYTES: begin
                    r_repl <= i_cfg_data[WIN_BITS-1:0];
                end
                CFG_REPLACEMENT_LENGTH: begin
                    r_rlen <= (i_cfg_data[3:0] > 4'd8) ? 4'd8 : i_cfg_data[3:0];
                end
                default: begin
                    r_rlen <= r_rlen;
                end
            endcase
        end
    end

    // Pending window; a new pattern length discards it
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_win <= '0;
            r_cnt <= 4'd0;
        end else if (i_cfg_we && (i_cfg_idx == CFG_PATTERN_LENGTH)) begin
            r_win <= '0;
            r_cnt <= 4'd0;
        end else if (i_take) begin
            r_win <= n_win;
            r_cnt <= n_cnt;
        end
    end

    a_cnt_below_plen: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt < r_plen)
        else $error("window count reached pattern length");

    a_plen_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_plen >= 4'd1) && (r_plen <= CAP))
        else $error("pattern length out of range");

endmodule

// ===== rtl/sfr_emit.sv =====
module sfr_emit (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_load,
    input  sfr_pkg::t_burst       i_burst,
    output logic                  o_space,
    output logic                  o_valid,
    input  logic                  i_ready,
    output sfr_pkg::t_out_word    o_data
);
    import sfr_pkg::*;

    logic                r_busy, n_busy;
    logic [WIN_BITS-1:0] r_bytes, n_bytes;
    logic [2:0]          r_left, n_left;
    logic                r_marker, n_marker;
    logic                r_last, n_last;
    logic                final_word;

    // Room for a new burst when idle or once the current one hands over its final word
    assign final_word = (r_left == 3'd0);
    assign o_space    = !r_busy || (i_ready && final_word);

    // Burst register: shift one word out per accepted output
    always_comb begin
        n_busy   = r_busy;
        n_bytes  = r_bytes;
        n_left   = r_left;
        n_marker = r_marker;
        n_last   = r_last;
        if (i_load) begin
            n_busy   = 1'b1;
            n_bytes  = i_burst.bytes;
            n_left   = i_burst.left;
            n_marker = i_burst.marker;
            n_last   = i_burst.last;
        end else if (r_busy && i_ready) begin
            if (final_word) begin
                n_busy = 1'b0;
            end else begin
                n_bytes = r_bytes >> 8;
                n_left  = r_left - 3'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_left <= 3'd0;
        end else begin
            r_busy <= n_busy;
            r_left <= n_left;
        end
    end

    always_ff @(posedge i_clk) begin
        r_bytes  <= n_bytes;
        r_marker <= n_marker;
        r_last   <= n_last;
    end

    // Output word
    assign o_valid             = r_busy;
    assign o_data.out_byte     = r_marker ? 8'h00 : r_bytes[7:0];
    assign o_data.byte_valid   = !r_marker;
    assign o_data.out_last     = r_last && final_word;

    a_marker_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_data.byte_valid |-> o_data.out_last && final_word)
        else $error("end marker not closing a text");

    a_no_load_mid_burst: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy && !final_word |-> !i_load)
        else $error("burst overwritten before drained");

    a_drain_goes_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy && i_ready && final_word && !i_load |=> !o_valid)
        else $error("output still valid after final word");

endmodule

// ===== rtl/stream_find_and_replace_core.sv =====
// Streaming find and replace over a byte text.
//
// Input channel (i_valid / o_ready, payload i_data): one character per word,
// in_last set on the final character of a text. Output channel (o_valid /
// i_ready, payload o_data): rewritten characters, out_last on the final word
// of a text; a word with byte_valid low is an end marker with no character.
// Configuration: i_cfg_we writes i_cfg_data to register i_cfg_idx
// (pattern bytes, pattern length, replacement bytes, replacement length);
// write only while idle. A pattern length write empties the pending window.
//
// A word that completes a result appears on the output in the cycle after
// it is accepted. Throughput: one input word per cycle while each word
// yields at most one output word. A match emits replacement_length words and
// the final word of a text emits the whole pending tail (up to 8 words); the
// burst register drains one word per cycle while i_ready is high and holds
// o_ready low until its last word is taken. When the receiver stalls, the
// burst register holds and input stops once it is full. Reset empties the
// window and burst register and loads defaults (pattern length 1, rest zero).
module stream_find_and_replace_core #(
    parameter int MAX_PATTERN = 8
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  sfr_pkg::t_cfg_idx     i_cfg_idx,
    input  logic [63:0]           i_cfg_data,
    input  logic                  i_valid,
    output logic                  o_ready,
    input  sfr_pkg::t_in_word     i_data,
    output logic                  o_valid,
    input  logic                  i_ready,
    output sfr_pkg::t_out_word    o_data
);
    import sfr_pkg::*;

    logic   space, take, load;
    t_burst burst;

    assign o_ready = space;
    assign take    = i_valid && space;

    sfr_window #(
        .MAX_PATTERN (MAX_PATTERN)
    ) u_window (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_take     (take),
        .i_word     (i_data),
        .o_load     (load),
        .o_burst    (burst)
    );

    sfr_emit u_emit (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (load),
        .i_burst (burst),
        .o_space (space),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .o_data  (o_data)
    );

endmodule
